FILE: hdl/msk_pll_pkg.sv
// ----------------------------------------------------------------------------
// msk_pll_pkg
// Shared types, constants and table functions of the MSK demodulator with
// carrier PLL.
// ----------------------------------------------------------------------------
package msk_pll_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int MUL_W        = 32;
  localparam int CORDIC_STEPS = 28;
  localparam int STEP_W       = 5;

  localparam logic [31:0] NCO_STEP_RST   = 32'd107374182;
  localparam logic [23:0] PLL_GAIN_RST   = 24'd16595;
  localparam logic [6:0]  FILTER_LEN_RST = 7'd40;

  localparam logic [32:0] THREE_QUARTER = 33'h0_C000_0000;
  localparam logic [31:0] QUARTER_TURN  = 32'h4000_0000;

  localparam logic signed [MUL_W-1:0] SIN_SEED = 32'sd172271;
  localparam logic signed [MUL_W-1:0] FC_DECAY = 32'sd1073204953;
  localparam logic signed [MUL_W-1:0] ERR_ZERO = 32'sd1057671045;

  typedef enum logic [1:0] {
    REG_NCO_STEP   = 2'd0,
    REG_PLL_GAIN   = 2'd1,
    REG_FILTER_LEN = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;
  } sample_t;

  typedef struct packed {
    logic       data_bit;
    logic       byte_valid;
    logic [7:0] byte_value;
  } result_t;

  typedef enum logic [4:0] {
    ST_FILL_INIT,
    ST_FILL_WR,
    ST_SIN,
    ST_IDLE,
    ST_MAC_A,
    ST_MAC_B,
    ST_MAC_C,
    ST_MAC_D,
    ST_DEC,
    ST_CORD,
    ST_LF1,
    ST_LF2,
    ST_LF3,
    ST_LF4,
    ST_MIX_C,
    ST_MUL_I,
    ST_MIX_S,
    ST_MUL_Q,
    ST_WR
  } state_t;

  typedef enum logic [1:0] {
    DST_FILL,
    DST_COS,
    DST_SIN
  } sin_dst_t;

  typedef struct packed {
    logic start;
    logic done;
  } cordic_ctl_t;

  function automatic logic signed [31:0] sin_coef(input logic [2:0] idx);
    logic signed [31:0] c;
    case (idx)
      3'd0:    c = -32'sd5027003;
      3'd1:    c = 32'sd85569307;
      3'd2:    c = -32'sd693598670;
      3'd3:    c = 32'sd1686629713;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] atan_turns(input logic [STEP_W-1:0] i);
    logic signed [31:0] a;
    case (i)
      5'd0:    a = 32'sd536870912;
      5'd1:    a = 32'sd316933406;
      5'd2:    a = 32'sd167458907;
      5'd3:    a = 32'sd85004756;
      5'd4:    a = 32'sd42667331;
      5'd5:    a = 32'sd21354465;
      5'd6:    a = 32'sd10679838;
      5'd7:    a = 32'sd5340245;
      5'd8:    a = 32'sd2670163;
      5'd9:    a = 32'sd1335087;
      5'd10:   a = 32'sd667544;
      5'd11:   a = 32'sd333772;
      5'd12:   a = 32'sd166886;
      5'd13:   a = 32'sd83443;
      5'd14:   a = 32'sd41722;
      5'd15:   a = 32'sd20861;
      5'd16:   a = 32'sd10430;
      5'd17:   a = 32'sd5215;
      5'd18:   a = 32'sd2608;
      5'd19:   a = 32'sd1304;
      5'd20:   a = 32'sd652;
      5'd21:   a = 32'sd326;
      5'd22:   a = 32'sd163;
      5'd23:   a = 32'sd81;
      5'd24:   a = 32'sd41;
      5'd25:   a = 32'sd20;
      5'd26:   a = 32'sd10;
      5'd27:   a = 32'sd5;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [15:0] sin_finish(input logic signed [31:0] s,
                                                    input logic neg);
    logic signed [32:0] r;
    if (s < 0) begin
      r = '0;
    end else begin
      r = (33'(s) + 33'sd16384) >>> 15;
    end
    if (r > 33'sd32767) begin
      r = 33'sd32767;
    end
    if (neg) begin
      r = -r;
    end
    return r[15:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] to_sample(
      input logic signed [63:0] prod);
    logic signed [63:0] r;
    r = (prod + 64'sd16384) >>> 15;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end else if (r < -64'sd32768) begin
      r = -64'sd32768;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/msk_pll_ram.sv
// ----------------------------------------------------------------------------
// msk_pll_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module msk_pll_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/msk_pll_mul.sv
// ----------------------------------------------------------------------------
// msk_pll_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module msk_pll_mul (
  input  logic                                clk,
  input  logic signed [msk_pll_pkg::MUL_W-1:0] a,
  input  logic signed [msk_pll_pkg::MUL_W-1:0] b,
  output logic signed [2*msk_pll_pkg::MUL_W-1:0] p
);

  import msk_pll_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: hdl/msk_pll_cordic.sv
// ----------------------------------------------------------------------------
// msk_pll_cordic
// Iterative vectoring CORDIC, one rotation per cycle, angle in turns * 2^32.
// ----------------------------------------------------------------------------
module msk_pll_cordic #(
  parameter int W = 40
) (
  input  logic                      clk,
  input  logic                      rst,
  input  msk_pll_pkg::cordic_ctl_t  ctl_in,
  output msk_pll_pkg::cordic_ctl_t  ctl_out,
  input  logic signed [W-1:0]       x_in,
  input  logic signed [W-1:0]       y_in,
  output logic signed [31:0]        z
);

  import msk_pll_pkg::*;

  logic signed [W-1:0]  x;
  logic signed [W-1:0]  y;
  logic signed [31:0]   zacc;
  logic [STEP_W-1:0]    i;
  logic                 busy;
  logic                 done;
  logic                 zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        busy <= 1'b1;
      end else if (busy && i == STEP_W'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      x    <= x_in;
      y    <= y_in;
      zacc <= '0;
      i    <= '0;
      zero <= (x_in == '0) && (y_in == '0);
    end else if (busy) begin
      if (y > 0) begin
        x    <= x + (y >>> i);
        y    <= y - (x >>> i);
        zacc <= zacc + atan_turns(i);
      end else begin
        x    <= x - (y >>> i);
        y    <= y + (x >>> i);
        zacc <= zacc - atan_turns(i);
      end
      i <= i + STEP_W'(1);
    end
  end

  assign ctl_out.start = busy;
  assign ctl_out.done  = done;
  assign z = zero ? '0 : zacc;

endmodule

FILE: hdl/msk_demodulator_pll_unit.sv
// ----------------------------------------------------------------------------
// msk_demodulator_pll_unit
// MSK demodulator with carrier PLL built around one shared multiplier.
// ----------------------------------------------------------------------------
// a sample without a symbol decision takes two sine polynomial passes
//   through the shared multiplier
// a symbol sample adds the matched filter and atan2; the bit leaves after
//   the matched filter, which uses the multiplier twice per tap
// no new sample is taken while busy
// reset: synchronous; afterwards, and after each nco_step write, the tap
//   table is refilled with sample_stall high
module msk_demodulator_pll_unit #(
  parameter int MAX_TAPS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  msk_pll_pkg::sample_t sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output msk_pll_pkg::result_t result,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  import msk_pll_pkg::*;

  localparam int IW    = $clog2(MAX_TAPS);
  localparam int LW    = IW + 1;
  localparam int ACC_W = 2 * SAMPLE_BITS + IW;
  localparam int CW    = ACC_W + 2;

  state_t   state;
  state_t   state_next;
  sin_dst_t sin_dst;

  logic [31:0] nco_step;
  logic [23:0] pll_gain;
  logic [6:0]  filter_len;

  logic [31:0]        carrier_phase;
  logic [31:0]        symbol_clock;
  logic signed [31:0] freq_correction;
  logic signed [31:0] last_phase_error;
  logic [1:0]         symbol_phase_state;
  logic [IW-1:0]      history_index;
  logic [7:0]         bit_shift;
  logic [3:0]         bit_count;
  logic [MAX_TAPS-1:0] hist_valid;
  logic               hist_valid_q;

  logic [LW-1:0]  len;
  logic [IW-1:0]  k;
  logic [IW-1:0]  j;
  logic signed [SAMPLE_BITS-1:0] si;
  logic signed [SAMPLE_BITS-1:0] sq;
  logic signed [ACC_W-1:0] iacc;
  logic signed [ACC_W-1:0] qacc;

  logic [31:0]        sin_ph;
  logic [2:0]         sc;
  logic signed [31:0] x2;
  logic signed [15:0] sinres;
  logic signed [SAMPLE_BITS-1:0] ih_s;
  logic signed [31:0] e;
  logic signed [31:0] t1;

  logic    out_valid;
  result_t out_reg;

  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [2*MUL_W-1:0] p;

  logic [SAMPLE_BITS-1:0] tap_rd;
  logic [SAMPLE_BITS-1:0] ih_rd;
  logic [SAMPLE_BITS-1:0] qh_rd;
  logic                   tap_we;
  logic                   hist_we;

  cordic_ctl_t        cor_in;
  cordic_ctl_t        cor_out;
  logic signed [CW-1:0] cor_x;
  logic signed [CW-1:0] cor_y;
  logic signed [31:0]   cor_z;

  logic [LW-1:0]  len_c;
  logic [IW-1:0]  hidx_c;
  logic [31:0]    step_c;
  logic [32:0]    clk_c;
  logic [32:0]    clk_m;
  logic           sym_c;
  logic           accept;
  logic           emit_ok;
  logic           bit_c;
  logic [7:0]     shift_c;
  logic [3:0]     count_c;

  logic [31:0]        sin_x;
  logic signed [31:0] p_sh;
  logic signed [31:0] tn;
  logic signed [31:0] t2_c;
  logic signed [33:0] fc_sum;
  logic signed [SAMPLE_BITS-1:0] tap_s;
  logic signed [SAMPLE_BITS-1:0] ih_m;
  logic signed [SAMPLE_BITS-1:0] qh_m;

  function automatic logic [31:0] p_sh_round(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + 64'sd536870912) >>> 30;
    return r[31:0];
  endfunction

  msk_pll_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  msk_pll_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (j),
    .wdata (sinres),
    .raddr (j),
    .rdata (tap_rd)
  );

  msk_pll_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_i_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (history_index),
    .wdata (ih_s),
    .raddr (k),
    .rdata (ih_rd)
  );

  msk_pll_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_q_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (history_index),
    .wdata (to_sample(p)),
    .raddr (k),
    .rdata (qh_rd)
  );

  msk_pll_cordic #(.W(CW)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (cor_in),
    .ctl_out (cor_out),
    .x_in    (cor_x),
    .y_in    (cor_y),
    .z       (cor_z)
  );

  // per-sample setup
  always_comb begin
    if (filter_len == '0) begin
      len_c = LW'(1);
    end else if ({25'd0, filter_len} > 32'(MAX_TAPS)) begin
      len_c = LW'(MAX_TAPS);
    end else begin
      len_c = LW'(filter_len);
    end
    hidx_c = ({1'b0, history_index} >= len_c) ? '0 : history_index;
    step_c = nco_step + freq_correction;
    clk_c  = {1'b0, symbol_clock} + {1'b0, step_c};
    sym_c  = clk_c > THREE_QUARTER;
    clk_m  = clk_c - THREE_QUARTER;
  end

  // sine polynomial, loop filter and matched filter operands
  always_comb begin
    sin_x = sin_ph[30] ? (32'h4000_0000 - {2'b00, sin_ph[29:0]}) : {2'b00, sin_ph[29:0]};
    p_sh  = $signed(p[61:30]);
    tn    = sin_coef(sc - 3'd2) + p_sh;
    t2_c  = $signed(p_sh_round(p));
    fc_sum = 34'(t1) + 34'(e) - 34'(t2_c);
    tap_s = $signed(tap_rd);
    ih_m  = hist_valid_q ? $signed(ih_rd) : '0;
    qh_m  = hist_valid_q ? $signed(qh_rd) : '0;
  end

  // symbol decision
  always_comb begin
    if (!symbol_phase_state[0]) begin
      bit_c = symbol_phase_state[1] ? (iacc > 0) : (iacc < 0);
      if (iacc >= 0) begin
        cor_y = -CW'(qacc);
        cor_x = CW'(iacc);
      end else begin
        cor_y = CW'(qacc);
        cor_x = -CW'(iacc);
      end
    end else begin
      bit_c = symbol_phase_state[1] ? (qacc < 0) : (qacc > 0);
      if (qacc >= 0) begin
        cor_y = CW'(iacc);
        cor_x = CW'(qacc);
      end else begin
        cor_y = -CW'(iacc);
        cor_x = -CW'(qacc);
      end
    end
    shift_c = {bit_shift[6:0], bit_c};
    count_c = bit_count + 4'd1;
  end

  assign accept       = sample_valid && !sample_stall;
  assign emit_ok      = !out_valid || !result_stall;
  assign sample_stall = (state != ST_IDLE);
  assign result_valid = out_valid;
  assign result       = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    mul_a        = '0;
    mul_b        = '0;
    tap_we       = 1'b0;
    hist_we      = 1'b0;
    cor_in.start = 1'b0;
    cor_in.done  = 1'b0;
    case (state)
      ST_FILL_INIT: state_next = ST_SIN;
      ST_FILL_WR: begin
        tap_we = 1'b1;
        state_next = (j == IW'(MAX_TAPS - 1)) ? ST_IDLE : ST_SIN;
      end
      ST_SIN: begin
        case (sc)
          3'd0: begin
            mul_a = sin_x;
            mul_b = sin_x;
          end
          3'd1: begin
            mul_a = SIN_SEED;
            mul_b = p_sh;
          end
          3'd5: begin
            mul_a = tn;
            mul_b = sin_x;
          end
          3'd6: begin
            case (sin_dst)
              DST_FILL: state_next = ST_FILL_WR;
              DST_COS:  state_next = ST_MUL_I;
              DST_SIN:  state_next = ST_MUL_Q;
              default:  state_next = ST_IDLE;
            endcase
          end
          default: begin
            mul_a = tn;
            mul_b = x2;
          end
        endcase
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = sym_c ? ST_MAC_A : ST_MIX_C;
        end
      end
      ST_MAC_A: state_next = ST_MAC_B;
      ST_MAC_B: begin
        mul_a = 32'(tap_s);
        mul_b = 32'(ih_m);
        state_next = ST_MAC_C;
      end
      ST_MAC_C: begin
        mul_a = 32'(tap_s);
        mul_b = 32'(qh_m);
        state_next = ST_MAC_D;
      end
      ST_MAC_D: state_next = ({1'b0, j} == len - LW'(1)) ? ST_DEC : ST_MAC_A;
      ST_DEC: begin
        if (emit_ok) begin
          cor_in.start = 1'b1;
          state_next = ST_CORD;
        end
      end
      ST_CORD: begin
        if (cor_out.done) begin
          state_next = ST_LF1;
        end
      end
      ST_LF1: begin
        mul_a = cor_z;
        mul_b = $signed({8'd0, pll_gain});
        state_next = ST_LF2;
      end
      ST_LF2: begin
        mul_a = freq_correction;
        mul_b = FC_DECAY;
        state_next = ST_LF3;
      end
      ST_LF3: begin
        mul_a = last_phase_error;
        mul_b = ERR_ZERO;
        state_next = ST_LF4;
      end
      ST_LF4:   state_next = ST_MIX_C;
      ST_MIX_C: state_next = ST_SIN;
      ST_MUL_I: begin
        mul_a = 32'(si);
        mul_b = 32'(sinres);
        state_next = ST_MIX_S;
      end
      ST_MIX_S: state_next = ST_SIN;
      ST_MUL_Q: begin
        mul_a = 32'(sq);
        mul_b = 32'(sinres);
        state_next = ST_WR;
      end
      ST_WR: begin
        hist_we = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    if (cfg_write && cfg_index == REG_NCO_STEP) begin
      state_next = ST_FILL_INIT;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      nco_step   <= NCO_STEP_RST;
      pll_gain   <= PLL_GAIN_RST;
      filter_len <= FILTER_LEN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NCO_STEP:   nco_step   <= cfg_data;
        REG_PLL_GAIN:   pll_gain   <= cfg_data[23:0];
        REG_FILTER_LEN: filter_len <= cfg_data[6:0];
        default:        ;
      endcase
    end
  end

  // loop and symbol state
  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_phase      <= '0;
      symbol_clock       <= '0;
      freq_correction    <= '0;
      last_phase_error   <= '0;
      symbol_phase_state <= '0;
      history_index      <= '0;
      bit_shift          <= '0;
      bit_count          <= '0;
      hist_valid         <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (state == ST_DEC && emit_ok) begin
        out_valid <= 1'b1;
      end else if (out_valid && !result_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            history_index <= hidx_c;
            carrier_phase <= carrier_phase + step_c;
            if (sym_c) begin
              symbol_clock <= clk_m[32] ? '1 : clk_m[31:0];
            end else begin
              symbol_clock <= clk_c[31:0];
            end
          end
        end
        ST_DEC: begin
          if (emit_ok) begin
            symbol_phase_state <= symbol_phase_state + 2'd1;
            out_reg.data_bit   <= bit_c;
            if (count_c >= 4'd8) begin
              out_reg.byte_valid <= 1'b1;
              out_reg.byte_value <= shift_c;
              bit_shift          <= '0;
              bit_count          <= '0;
            end else begin
              out_reg.byte_valid <= 1'b0;
              out_reg.byte_value <= '0;
              bit_shift          <= shift_c;
              bit_count          <= count_c;
            end
          end
        end
        ST_LF4: begin
          freq_correction  <= sat32(64'(fc_sum));
          last_phase_error <= e;
        end
        ST_WR: begin
          hist_valid[history_index] <= 1'b1;
          history_index <= (({1'b0, history_index} + LW'(1)) == len) ? '0
                           : history_index + IW'(1);
        end
        default: ;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    hist_valid_q <= hist_valid[k];
    case (state)
      ST_FILL_INIT: begin
        j       <= '0;
        sin_ph  <= nco_step;
        sin_dst <= DST_FILL;
        sc      <= '0;
      end
      ST_FILL_WR: begin
        j      <= j + IW'(1);
        sin_ph <= sin_ph + nco_step;
        sc     <= '0;
      end
      ST_SIN: begin
        sc <= sc + 3'd1;
        if (sc == 3'd1) begin
          x2 <= p_sh;
        end else if (sc == 3'd6) begin
          sinres <= sin_finish(p_sh, sin_ph[31]);
        end
      end
      ST_IDLE: begin
        si   <= sample.sample_i;
        sq   <= sample.sample_q;
        len  <= len_c;
        j    <= '0;
        iacc <= '0;
        qacc <= '0;
        k    <= (({1'b0, hidx_c} + LW'(1)) == len_c) ? '0 : hidx_c + IW'(1);
      end
      ST_MAC_C: iacc <= iacc + ACC_W'(p);
      ST_MAC_D: begin
        qacc <= qacc + ACC_W'(p);
        j    <= j + IW'(1);
        k    <= (({1'b0, k} + LW'(1)) == len) ? '0 : k + IW'(1);
      end
      ST_LF2: e  <= sat32(p >>> 24);
      ST_LF3: t1 <= $signed(p_sh_round(p));
      ST_MIX_C: begin
        sin_ph  <= carrier_phase + QUARTER_TURN;
        sin_dst <= DST_COS;
        sc      <= '0;
      end
      ST_MIX_S: begin
        ih_s    <= to_sample(p);
        sin_ph  <= carrier_phase;
        sin_dst <= DST_SIN;
        sc      <= '0;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/msk_pll_chk.sv
// ----------------------------------------------------------------------------
// msk_pll_chk
// Port-level checks of the MSK demodulator with carrier PLL.
// ----------------------------------------------------------------------------
module msk_pll_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 sample_valid,
  input logic                 sample_stall,
  input msk_pll_pkg::sample_t sample,
  input logic                 result_valid,
  input logic                 result_stall,
  input msk_pll_pkg::result_t result,
  input logic                 cfg_write,
  input logic [1:0]           cfg_index,
  input logic [31:0]          cfg_data
);

  import msk_pll_pkg::*;

  logic unused_in;
  assign unused_in = ^{sample, cfg_data};

  // tap table refill after reset
  a_fill_after_reset: assert property (@(posedge clk) disable iff (rst)
      $past(rst) |-> sample_stall)
    else $error("sample taken during tap refill");

  // one sample transaction at a time
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
      (sample_valid && !sample_stall) |=> sample_stall)
    else $error("sample taken while busy");

  // step change refills taps
  a_refill_on_step: assert property (@(posedge clk) disable iff (rst)
      (cfg_write && cfg_index == REG_NCO_STEP) |=> sample_stall)
    else $error("no refill after step write");

  // partial byte reads as zero
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
      (result_valid && !result.byte_valid) |-> result.byte_value == 8'd0)
    else $error("byte value without byte");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
      (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind msk_demodulator_pll_unit msk_pll_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .sample       (sample),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .cfg_write    (cfg_write),
  .cfg_index    (cfg_index),
  .cfg_data     (cfg_data)
);

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the MSK demodulator with carrier PLL. A
// bit-exact demodulator model predicts each decided bit and byte, and each
// result transaction is checked against it. The run covers directed
// extremes, synthetic MSK tones and noise, and several register settings,
// with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import msk_pll_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  sample_t     sample = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  msk_demodulator_pll_unit uut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  sample_t pending_samples[$];
  result_t expected_bits[$];
  int      mismatches = 0;
  int      send_idle = 0;
  int      recv_stall = 0;

  // demodulator model state
  logic [31:0] m_step, m_phase, m_sclk;
  logic [23:0] m_gain;
  logic [6:0]  m_len;
  int          m_fc, m_last;
  logic [1:0]  m_sps;
  int          m_hidx, m_cnt;
  logic [7:0]  m_shift;
  longint      i_hist[64], q_hist[64], taps[64];

  function automatic longint sin_q15(logic [31:0] ph);
    longint f, x, x2, t, s, r;
    f = longint'(ph[29:0]);
    x = ph[30] ? (longint'(1) <<< 30) - f : f;
    x2 = (x * x) >>> 30;
    t = 172271;
    t = -5027003 + ((t * x2) >>> 30);
    t = 85569307 + ((t * x2) >>> 30);
    t = -693598670 + ((t * x2) >>> 30);
    t = 1686629713 + ((t * x2) >>> 30);
    s = (t * x) >>> 30;
    if (s < 0) s = 0;
    r = (s + 16384) >>> 15;
    if (r > 32767) r = 32767;
    return ph[31] ? -r : r;
  endfunction

  function automatic int sat_word(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic longint mix_round(longint prod);
    longint r;
    r = (prod + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic int phase_of(longint y, longint x);
    longint z, nx;
    z = 0;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_turns(i[STEP_W-1:0]);
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_turns(i[STEP_W-1:0]);
      end
      x = nx;
    end
    return sat_word(z);
  endfunction

  function automatic void load_taps();
    for (int j = 0; j < 64; j++) taps[j] = sin_q15(m_step * 32'(j + 1));
  endfunction

  function automatic void model_reset();
    m_step = NCO_STEP_RST; m_gain = PLL_GAIN_RST; m_len = FILTER_LEN_RST;
    m_phase = '0; m_sclk = '0; m_fc = 0; m_last = 0; m_sps = '0;
    m_hidx = 0; m_cnt = 0; m_shift = '0;
    for (int j = 0; j < 64; j++) begin
      i_hist[j] = 0;
      q_hist[j] = 0;
    end
    load_taps();
  endfunction

  function automatic void demod_predict(sample_t s);
    int          len, err, e;
    logic [31:0] p;
    longint      clk33, iv, qv, decision, fc;
    logic        bit_v;
    result_t     r;
    len = (m_len == 0) ? 1 : ((m_len > 64) ? 64 : int'(m_len));
    p = m_step + m_fc;
    clk33 = longint'(m_sclk) + longint'(p);
    if (m_hidx >= len) m_hidx = 0;
    m_phase += p;
    if (clk33 > 64'h0_C000_0000) begin
      clk33 -= 64'h0_C000_0000;
      iv = 0;
      qv = 0;
      for (int j = 0; j < len; j++) begin
        iv += taps[j] * i_hist[(m_hidx + 1 + j) % len];
        qv += taps[j] * q_hist[(m_hidx + 1 + j) % len];
      end
      if (!m_sps[0]) begin
        err = (iv >= 0) ? phase_of(-qv, iv) : phase_of(qv, -iv);
        decision = -iv;
      end else begin
        err = (qv >= 0) ? phase_of(iv, qv) : phase_of(-iv, -qv);
        decision = qv;
      end
      if (m_sps[1]) decision = -decision;
      bit_v = decision > 0;
      m_sps += 2'd1;
      m_shift = {m_shift[6:0], bit_v};
      m_cnt++;
      r.data_bit = bit_v;
      if (m_cnt >= 8) begin
        r.byte_valid = 1'b1;
        r.byte_value = m_shift;
        m_shift = '0;
        m_cnt = 0;
      end else begin
        r.byte_valid = 1'b0;
        r.byte_value = '0;
      end
      expected_bits.push_back(r);
      e = sat_word((longint'(err) * longint'(m_gain)) >>> 24);
      fc = ((longint'(m_fc) * 1073204953 + (longint'(1) <<< 29)) >>> 30) + e
         - ((longint'(m_last) * 1057671045 + (longint'(1) <<< 29)) >>> 30);
      m_fc = sat_word(fc);
      m_last = e;
    end
    m_sclk = (clk33 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : clk33[31:0];
    i_hist[m_hidx] = mix_round(longint'(s.sample_i) * sin_q15(m_phase + QUARTER_TURN));
    q_hist[m_hidx] = mix_round(longint'(s.sample_q) * sin_q15(m_phase));
    m_hidx = (m_hidx + 1) % len;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) demod_predict(sample);
      if (!sample_valid || !sample_stall) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle) begin
          sample <= pending_samples.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_bits.size() == 0) begin
          flag_mismatch("unexpected transaction", int'(result), 0);
        end else begin
          result_t want;
          want = expected_bits.pop_front();
          if (result.data_bit !== want.data_bit)
            flag_mismatch("data_bit", result.data_bit, want.data_bit);
          if (result.byte_valid !== want.byte_valid)
            flag_mismatch("byte_valid", result.byte_valid, want.byte_valid);
          if (result.byte_value !== want.byte_value)
            flag_mismatch("byte_value", result.byte_value, want.byte_value);
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  task automatic settle();
    while (pending_samples.size() > 0 || sample_valid || expected_bits.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_NCO_STEP: begin
        m_step = value;
        load_taps();
      end
      REG_PLL_GAIN:   m_gain = value[23:0];
      REG_FILTER_LEN: m_len = value[6:0];
      default: ;
    endcase
  endtask

  function automatic sample_t pick(int i, int q);
    sample_t s;
    s.sample_i = i[15:0];
    s.sample_q = q[15:0];
    return s;
  endfunction

  task automatic queue_random(int count);
    real ph, amp, dph;
    int  left, ni, nq;
    ph = 0.0;
    while (count > 0) begin
      if ($urandom_range(9) < 8) begin
        left = $urandom_range(60, 10);
        amp = $urandom_range(30000, 2000);
        dph = 0.0;
        while (left > 0 && count > 0) begin
          if ($urandom_range(15) == 0) dph = ($urandom_range(1) ? 0.05 : -0.05);
          ph += dph;
          ni = $rtoi(amp * $cos(ph)) + $urandom_range(500) - 250;
          nq = $rtoi(amp * $sin(ph)) + $urandom_range(500) - 250;
          pending_samples.push_back(pick(ni, nq));
          left--;
          count--;
        end
      end else begin
        pending_samples.push_back(pick($urandom, $urandom));
        count--;
      end
    end
  endtask

  initial begin
    logic [31:0] steps[7] = '{32'd107374182, 32'h2000_0000, 32'h0, 32'hFFFF_FFFF,
                              32'h0800_0000, 32'h0400_0000, 32'd107374182};
    logic [31:0] gains[7] = '{32'd16595, 32'hFF_FFFF, 32'h0, 32'd16595,
                              32'd1000, 32'd200000, 32'd16595};
    logic [31:0] lens[7]  = '{32'd40, 32'd8, 32'd0, 32'd1, 32'd64, 32'd127, 32'd40};
    int idle_s[4] = '{0, 50, 0, 37};
    int idle_r[4] = '{0, 0, 50, 37};
    model_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 7; ph++) begin
      send_idle = idle_s[ph % 4];
      recv_stall = idle_r[ph % 4];
      write_reg(REG_NCO_STEP, steps[ph]);
      write_reg(REG_PLL_GAIN, gains[ph]);
      write_reg(REG_FILTER_LEN, lens[ph]);
      if (ph == 0) begin
        // field extremes and a zero run
        for (int k = 0; k < 8; k++) pending_samples.push_back(pick(0, 0));
        pending_samples.push_back(pick(32767, 32767));
        pending_samples.push_back(pick(-32768, -32768));
        pending_samples.push_back(pick(32767, -32768));
        pending_samples.push_back(pick(-32768, 32767));
        pending_samples.push_back(pick(-1, 1));
        pending_samples.push_back(pick(1, -1));
        for (int k = 0; k < 10; k++)
          pending_samples.push_back(pick((k & 1) ? 32767 : -32768, (k & 2) ? -32768 : 32767));
        // sender holds off until everything has drained
        while (pending_samples.size() > 0 || sample_valid || expected_bits.size() > 0)
          @(posedge clk);
      end
      queue_random((ph == 3) ? 50 : 220);
      settle();
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
hdl/msk_pll_pkg.sv
hdl/msk_pll_ram.sv
hdl/msk_pll_mul.sv
hdl/msk_pll_cordic.sv
hdl/msk_demodulator_pll_unit.sv
hdl/msk_pll_chk.sv
verif/tb_top.sv
